// ===== rtl/core/gcc_pkg.sv =====
// Greedy coin change: shared types and constants.
// Used by gcc_cell, gcc_divider, greedy_coin_change, coin_change_checker and the testbench; depends on nothing.
package gcc_pkg;

	localparam int DENOM_W        = 16;
	localparam int NUM_DENOM_REGS = 4;
	localparam int DIX_W          = 2;
	localparam int INUSE_W        = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int COUNT_W        = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DENOM_FIRST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DENOM_SECOND  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DENOM_THIRD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DENOM_FOURTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DENOMS_IN_USE = 3'd4;

	// reset values
	localparam logic [DENOM_W-1:0] RST_DENOM_FIRST   = 16'd1;
	localparam logic [DENOM_W-1:0] RST_DENOM_SECOND  = 16'd5;
	localparam logic [DENOM_W-1:0] RST_DENOM_THIRD   = 16'd10;
	localparam logic [DENOM_W-1:0] RST_DENOM_FOURTH  = 16'd25;
	localparam logic [INUSE_W-1:0] RST_DENOMS_IN_USE = 3'd4;

	// control broadcast to every sort cell
	typedef struct packed {
		logic clear;
		logic sort_en;
		logic shift_en;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/greedy_coin_change.sv =====
// Greedy coin change, top level: config registers, sorting chain, divider and control.
// Depends on gcc_pkg, gcc_cell and gcc_divider.
//
// Takes one amount per input transaction and makes it up greedily from up to
// four configured coin denominations, largest first whatever their register
// order. The denominations in use (a zero register counts as absent) are fed
// one per cycle into a chain of N = min(MAX_DENOMS, 4) sorting cells, each of
// which keeps the larger value and hands the smaller to its neighbour; at the
// end of the sort state the chain holds them in descending order with the
// largest at its head. The chain then shifts towards its head, one
// denomination per step, and a shared restoring divider takes the quotient and
// remainder of the running amount by the head denomination, one bit per cycle.
// One item is worked on at a time; the next input transaction is taken as soon
// as the previous result sits in the output register, even if that result has
// not yet been taken. A remainder left over raises cannot_make and forces
// coin_total to 0; a count above 65535 saturates. Config writes are expected
// only while the block is idle; indexes beyond 4 are ignored.
module greedy_coin_change #(
	parameter int MAX_DENOMS   = 4,
	parameter int AMOUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [gcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gcc_pkg::DENOM_W-1:0]       cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [AMOUNT_WIDTH-1:0]           amount,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [gcc_pkg::COUNT_W-1:0]       coin_total,
	output logic                              cannot_make
);

	localparam int NCELL = (MAX_DENOMS < gcc_pkg::NUM_DENOM_REGS) ?
		MAX_DENOMS : gcc_pkg::NUM_DENOM_REGS;
	localparam int SC_W  = $clog2(2 * NCELL) + 1;
	localparam int XW    = (AMOUNT_WIDTH > gcc_pkg::COUNT_W) ? AMOUNT_WIDTH : gcc_pkg::COUNT_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SORT   = 5'b00010,
		ST_LOAD   = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [gcc_pkg::DENOM_W-1:0] denom_q [gcc_pkg::NUM_DENOM_REGS];
	logic [gcc_pkg::INUSE_W-1:0] inuse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denom_q[0] <= gcc_pkg::RST_DENOM_FIRST;
			denom_q[1] <= gcc_pkg::RST_DENOM_SECOND;
			denom_q[2] <= gcc_pkg::RST_DENOM_THIRD;
			denom_q[3] <= gcc_pkg::RST_DENOM_FOURTH;
			inuse_q    <= gcc_pkg::RST_DENOMS_IN_USE;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				gcc_pkg::REG_DENOM_FIRST:   denom_q[0] <= cfg_data;
				gcc_pkg::REG_DENOM_SECOND:  denom_q[1] <= cfg_data;
				gcc_pkg::REG_DENOM_THIRD:   denom_q[2] <= cfg_data;
				gcc_pkg::REG_DENOM_FOURTH:  denom_q[3] <= cfg_data;
				gcc_pkg::REG_DENOMS_IN_USE: inuse_q    <= cfg_data[gcc_pkg::INUSE_W-1:0];
				default: ;
			endcase
		end
	end

	// denominations in use, saturated to the chain length
	logic [gcc_pkg::INUSE_W-1:0] used;
	logic [SC_W-1:0]             used_c;

	assign used   = (inuse_q > gcc_pkg::INUSE_W'(NCELL)) ? gcc_pkg::INUSE_W'(NCELL) : inuse_q;
	assign used_c = SC_W'(used);

	// control
	logic                        in_acc;
	logic [SC_W-1:0]             sort_cnt_q;
	logic [AMOUNT_WIDTH-1:0]     rem_q;
	logic [AMOUNT_WIDTH-1:0]     count_q;
	gcc_pkg::cell_ctrl_t         cell_ctrl;
	logic [gcc_pkg::DENOM_W-1:0] feed;
	logic                        div_start;
	logic                        div_done;
	logic [AMOUNT_WIDTH-1:0]     div_quot;
	logic [gcc_pkg::DENOM_W-1:0] div_rem;
	logic                        out_load;

	logic [gcc_pkg::DENOM_W-1:0] hold [NCELL];
	logic [gcc_pkg::DENOM_W-1:0] pass [NCELL];

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	assign feed = (sort_cnt_q < used_c) ? denom_q[gcc_pkg::DIX_W'(sort_cnt_q)] : '0;

	assign cell_ctrl.clear    = in_acc;
	assign cell_ctrl.sort_en  = (state_q == ST_SORT);
	assign cell_ctrl.shift_en = (state_q == ST_DIV) && div_done;

	// a zero at the head means every denomination has been used
	assign div_start = (state_q == ST_LOAD) && (hold[0] != '0);
	assign out_load  = (state_q == ST_FINISH) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sort_cnt_q <= '0;
			rem_q      <= '0;
			count_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rem_q      <= amount;
						count_q    <= '0;
						sort_cnt_q <= '0;
						state_q    <= ST_SORT;
					end
				end
				ST_SORT: begin
					if (sort_cnt_q == SC_W'(2 * NCELL - 2)) begin
						state_q <= ST_LOAD;
					end else begin
						sort_cnt_q <= sort_cnt_q + 1'b1;
					end
				end
				ST_LOAD: begin
					state_q <= div_start ? ST_DIV : ST_FINISH;
				end
				ST_DIV: begin
					if (div_done) begin
						count_q <= count_q + div_quot;
						rem_q   <= AMOUNT_WIDTH'(div_rem);
						state_q <= ST_LOAD;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sorting chain
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		logic [gcc_pkg::DENOM_W-1:0] cell_in;
		logic [gcc_pkg::DENOM_W-1:0] cell_next;

		if (k == 0) begin : g_head
			assign cell_in = feed;
		end else begin : g_body
			assign cell_in = pass[k-1];
		end

		if (k == NCELL - 1) begin : g_tail
			assign cell_next = '0;
		end else begin : g_inner
			assign cell_next = hold[k+1];
		end

		gcc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl),
			.in_val    (cell_in),
			.next_hold (cell_next),
			.hold_val  (hold[k]),
			.pass_val  (pass[k])
		);
	end

	gcc_divider #(
		.AMOUNT_WIDTH (AMOUNT_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rem_q),
		.divisor   (hold[0]),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// result register
	logic [XW-1:0]                count_x;
	logic [gcc_pkg::COUNT_W-1:0]  count_sat;
	logic                         out_valid_q;
	logic [gcc_pkg::COUNT_W-1:0]  coin_total_q;
	logic                         cannot_make_q;

	assign count_x   = XW'(count_q);
	assign count_sat = (count_x > XW'(gcc_pkg::COUNT_MAX)) ?
		gcc_pkg::COUNT_MAX : gcc_pkg::COUNT_W'(count_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			coin_total_q  <= '0;
			cannot_make_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q   <= 1'b1;
			cannot_make_q <= (rem_q != '0);
			coin_total_q  <= (rem_q != '0) ? '0 : count_sat;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign coin_total  = coin_total_q;
	assign cannot_make = cannot_make_q;

`ifndef SYNTHESIS
	a_fail_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cannot_make |-> coin_total == '0)
		else $error("coin_total not zero with cannot_make");

	a_accept_sorts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_SORT)
		else $error("accepted transaction did not start sorting");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_rem < hold[0])
		else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/core/gcc_cell.sv =====
// One cell of the sorting chain: keeps the larger value, passes the smaller on.
// Depends on gcc_pkg.
module gcc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gcc_pkg::cell_ctrl_t          ctrl,
	input  logic [gcc_pkg::DENOM_W-1:0]  in_val,
	input  logic [gcc_pkg::DENOM_W-1:0]  next_hold,
	output logic [gcc_pkg::DENOM_W-1:0]  hold_val,
	output logic [gcc_pkg::DENOM_W-1:0]  pass_val
);

	logic [gcc_pkg::DENOM_W-1:0] hold_q;
	logic [gcc_pkg::DENOM_W-1:0] pass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			pass_q <= '0;
		end else if (ctrl.clear) begin
			hold_q <= '0;
			pass_q <= '0;
		end else if (ctrl.sort_en) begin
			if (in_val > hold_q) begin
				hold_q <= in_val;
				pass_q <= hold_q;
			end else begin
				pass_q <= in_val;
			end
		end else if (ctrl.shift_en) begin
			// step towards the head of the chain
			hold_q <= next_hold;
		end
	end

	assign hold_val = hold_q;
	assign pass_val = pass_q;

endmodule

// ===== rtl/core/gcc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gcc_pkg.
module gcc_divider #(
	parameter int AMOUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [AMOUNT_WIDTH-1:0]      dividend,
	input  logic [gcc_pkg::DENOM_W-1:0]  divisor,
	output logic                         done,
	output logic [AMOUNT_WIDTH-1:0]      quotient,
	output logic [gcc_pkg::DENOM_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(AMOUNT_WIDTH);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [AMOUNT_WIDTH-1:0]       q_q;
	logic [gcc_pkg::DENOM_W-1:0]   r_q;
	logic [gcc_pkg::DENOM_W-1:0]   d_q;
	logic [gcc_pkg::DENOM_W:0]     r_shift;
	logic [gcc_pkg::DENOM_W:0]     r_diff;
	logic                          q_bit;

	always_comb begin
		r_shift = {r_q, q_q[AMOUNT_WIDTH-1]};
		r_diff  = r_shift - {1'b0, d_q};
		q_bit   = (r_shift >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(AMOUNT_WIDTH - 1);
				q_q    <= dividend;
				r_q    <= '0;
				d_q    <= divisor;
			end else if (busy_q) begin
				// dividend bits leave at the top, quotient bits enter at the bottom
				q_q <= {q_q[AMOUNT_WIDTH-2:0], q_bit};
				r_q <= q_bit ? r_diff[gcc_pkg::DENOM_W-1:0] : r_shift[gcc_pkg::DENOM_W-1:0];
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = q_q;
	assign remainder = r_q;

endmodule

// ===== verif/coin_change_checker.sv =====
// Checker for greedy_coin_change: follows config writes, predicts every result
// from its own register copy and compares results in order. Depends on gcc_pkg.
module coin_change_checker #(
	parameter int MAX_DENOMS   = 4,
	parameter int AMOUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcc_pkg::DENOM_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [AMOUNT_WIDTH-1:0]       amount,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [gcc_pkg::COUNT_W-1:0]   coin_total,
	input  logic                          cannot_make,
	output int                            mismatches,
	output int                            pending
);

	typedef struct packed {
		logic [gcc_pkg::COUNT_W-1:0] coins;
		logic                        unmade;
	} change_t;

	typedef struct packed {
		logic [AMOUNT_WIDTH-1:0] amount;
		change_t                 want;
	} owed_t;

	logic [gcc_pkg::DENOM_W-1:0] denom [gcc_pkg::NUM_DENOM_REGS];
	logic [gcc_pkg::INUSE_W-1:0] in_use;
	owed_t                       owed_q [$];

	// largest denomination first; zero registers take no part
	function automatic change_t greedy_change(input logic [AMOUNT_WIDTH-1:0] amt);
		logic [gcc_pkg::DENOM_W-1:0] order [gcc_pkg::NUM_DENOM_REGS];
		logic [AMOUNT_WIDTH-1:0]     rest;
		logic [63:0]                 total;
		change_t                     res;
		int                          lim, n, i, j;
		lim = int'(in_use);
		if (lim > MAX_DENOMS)
			lim = MAX_DENOMS;
		if (lim > gcc_pkg::NUM_DENOM_REGS)
			lim = gcc_pkg::NUM_DENOM_REGS;
		n = 0;
		for (i = 0; i < lim; i++) begin
			if (denom[i] != '0) begin
				j = n;
				while (j > 0 && order[j-1] < denom[i]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = denom[i];
				n++;
			end
		end
		rest  = amt;
		total = '0;
		for (i = 0; i < n; i++) begin
			total += rest / order[i];
			rest   = rest % order[i];
		end
		if (rest != '0) begin
			res.coins  = '0;
			res.unmade = 1'b1;
		end else begin
			res.coins  = (total > gcc_pkg::COUNT_MAX) ?
				gcc_pkg::COUNT_MAX : total[gcc_pkg::COUNT_W-1:0];
			res.unmade = 1'b0;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		owed_t head;
		owed_t fresh;
		if (!arst_n) begin
			denom[0] = gcc_pkg::RST_DENOM_FIRST;
			denom[1] = gcc_pkg::RST_DENOM_SECOND;
			denom[2] = gcc_pkg::RST_DENOM_THIRD;
			denom[3] = gcc_pkg::RST_DENOM_FOURTH;
			in_use   = gcc_pkg::RST_DENOMS_IN_USE;
			owed_q.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					gcc_pkg::REG_DENOM_FIRST:   denom[0] = cfg_data;
					gcc_pkg::REG_DENOM_SECOND:  denom[1] = cfg_data;
					gcc_pkg::REG_DENOM_THIRD:   denom[2] = cfg_data;
					gcc_pkg::REG_DENOM_FOURTH:  denom[3] = cfg_data;
					gcc_pkg::REG_DENOMS_IN_USE: in_use = cfg_data[gcc_pkg::INUSE_W-1:0];
					default: ;
				endcase
			end
			// a result at this edge belongs to an amount taken earlier
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: expected no result, got count %0d cannot_make %0b",
						$time, coin_total, cannot_make);
					mismatches <= mismatches + 1;
				end else begin
					head = owed_q.pop_front();
					if (coin_total !== head.want.coins || cannot_make !== head.want.unmade) begin
						$display("%0t: amount %0d expected %0d/%0b, got %0d/%0b (count/cannot_make)",
							$time, head.amount, head.want.coins, head.want.unmade,
							coin_total, cannot_make);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				fresh.amount = amount;
				fresh.want   = greedy_change(amount);
				owed_q.push_back(fresh);
			end
			pending <= owed_q.size();
		end
	end

endmodule

// ===== verif/greedy_coin_change_test.sv =====
// Testbench top for greedy_coin_change: clock, reset, config writes, amount and
// result handshakes, watchdog and verdict. Depends on gcc_pkg, the block and coin_change_checker.
module greedy_coin_change_test;

	localparam int MAX_DENOMS      = 4;
	localparam int AMOUNT_WIDTH    = 16;
	localparam int NUM_PHASES      = 9;
	localparam int ITEMS_PER_PHASE = 60;
	localparam int HOLD_PHASE      = 2;
	// long output stall; must comfortably exceed two item times
	localparam int LONG_HOLD       = 400;
	// quiet cycles allowed: long stall plus one item plus gaps, several times over
	localparam int STALL_LIMIT     = 3000;
	// settle time after the last result, about one item time
	localparam int TAIL_CYCLES     = 100;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [gcc_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [gcc_pkg::DENOM_W-1:0]      cfg_data;
	logic                             in_valid;
	logic                             in_ready;
	logic [AMOUNT_WIDTH-1:0]          amount;
	logic                             out_valid;
	logic                             out_ready;
	logic [gcc_pkg::COUNT_W-1:0]      coin_total;
	logic                             cannot_make;

	int mismatches;
	int pending;

	// stimulus-side bookkeeping; the checker keeps its own register copy
	logic [gcc_pkg::DENOM_W-1:0] cur_den [gcc_pkg::NUM_DENOM_REGS];
	logic                        hold_req;
	int                          idle_pct;
	int                          sent;
	int                          settings;

	greedy_coin_change #(
		.MAX_DENOMS  (MAX_DENOMS),
		.AMOUNT_WIDTH(AMOUNT_WIDTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coin_total (coin_total),
		.cannot_make(cannot_make)
	);

	coin_change_checker #(
		.MAX_DENOMS  (MAX_DENOMS),
		.AMOUNT_WIDTH(AMOUNT_WIDTH)
	) coin_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.amount     (amount),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.coin_total (coin_total),
		.cannot_make(cannot_make),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Denomination mix: mostly small coins so random sums can be made up, some
	// full-range values, the top value, and the odd zero register.
	function automatic logic [gcc_pkg::DENOM_W-1:0] rand_denom();
		case ($urandom_range(0, 19))
			0, 1:    return '0;
			2:       return '1;
			3, 4, 5: return gcc_pkg::DENOM_W'($urandom_range(1, 65535));
			default: return gcc_pkg::DENOM_W'($urandom_range(1, 40));
		endcase
	endfunction

	// Mostly 1..4 in use; now and then none, or more than there are registers.
	// Upper bits are junk so the 3-bit field has to be picked out.
	function automatic logic [gcc_pkg::DENOM_W-1:0] rand_in_use_word();
		logic [gcc_pkg::INUSE_W-1:0]                  n;
		logic [31:0]                                  junk;
		logic [gcc_pkg::DENOM_W-gcc_pkg::INUSE_W-1:0] upper;
		junk  = $urandom;
		upper = junk[gcc_pkg::DENOM_W-1:gcc_pkg::INUSE_W];
		case ($urandom_range(0, 9))
			0:       n = '0;
			1:       n = gcc_pkg::INUSE_W'($urandom_range(5, 7));
			default: n = gcc_pkg::INUSE_W'($urandom_range(1, 4));
		endcase
		return {upper, n};
	endfunction

	// Full-range amounts, small amounts, and sums of configured coins (which
	// tend to be makeable, so the count path gets exercised properly).
	function automatic logic [AMOUNT_WIDTH-1:0] pick_amount();
		logic [AMOUNT_WIDTH-1:0] acc;
		logic [31:0]             part;
		int                      r, i;
		r = $urandom_range(0, 99);
		if (r < 35)
			return AMOUNT_WIDTH'($urandom);
		if (r < 60)
			return AMOUNT_WIDTH'($urandom_range(0, 200));
		acc = '0;
		for (i = 0; i < 3; i++) begin
			part = $urandom_range(0, 20) *
				32'(cur_den[$urandom_range(0, gcc_pkg::NUM_DENOM_REGS - 1)]);
			acc  = acc + AMOUNT_WIDTH'(part);
		end
		return acc;
	endfunction

	// One amount transaction; valid stays up until the block takes it, then
	// either stays up for the next one or drops for a short burst.
	task automatic offer(input logic [AMOUNT_WIDTH-1:0] a);
		in_valid <= 1'b1;
		amount   <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// Stop offering and wait for every owed result. The first edge lets the
	// checker's count catch up with a transaction taken at this very edge.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [gcc_pkg::CFG_IDX_W-1:0] idx,
			input logic [gcc_pkg::DENOM_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Writes all five registers back to back; optionally one write to an
	// unused index, which the block must ignore.
	task automatic program_regs(input logic [gcc_pkg::DENOM_W-1:0] d0, d1, d2, d3, in_use_word,
			input bit stray);
		logic [gcc_pkg::CFG_IDX_W-1:0] idx;
		cfg_wr_en <= 1'b1;
		put_reg(gcc_pkg::REG_DENOM_FIRST, d0);
		put_reg(gcc_pkg::REG_DENOM_SECOND, d1);
		put_reg(gcc_pkg::REG_DENOM_THIRD, d2);
		put_reg(gcc_pkg::REG_DENOM_FOURTH, d3);
		put_reg(gcc_pkg::REG_DENOMS_IN_USE, in_use_word);
		if (stray) begin
			idx = gcc_pkg::REG_DENOMS_IN_USE + gcc_pkg::CFG_IDX_W'($urandom_range(1, 3));
			put_reg(idx, gcc_pkg::DENOM_W'($urandom));
		end
		cfg_wr_en  <= 1'b0;
		cur_den[0] = d0;
		cur_den[1] = d1;
		cur_den[2] = d2;
		cur_den[3] = d3;
		settings++;
	endtask

	// Result side: random short stalls at the phase's idle rate, plus one long
	// hold-off on request so the block fills and back-pressures its input.
	initial begin : receiver
		bit long_done;
		long_done = 1'b0;
		out_ready = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_req && !long_done) begin
				out_ready <= 1'b0;
				long_done = 1'b1;
				repeat (LONG_HOLD)
					@(posedge clk);
			end else if ($urandom_range(0, 99) < idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4))
					@(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Watchdog: ends the run if no transaction or config write is seen for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transaction for %0d cycles, %0d results still owed",
			$time, quiet, pending);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		int p, k;
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		amount     = '0;
		hold_req   = 1'b0;
		idle_pct   = 20;
		sent       = 0;
		settings   = 1;
		cur_den[0] = gcc_pkg::RST_DENOM_FIRST;
		cur_den[1] = gcc_pkg::RST_DENOM_SECOND;
		cur_den[2] = gcc_pkg::RST_DENOM_THIRD;
		cur_den[3] = gcc_pkg::RST_DENOM_FOURTH;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coins 1/5/10/25: zero amount, extremes, a few greedy mixes
		offer(AMOUNT_WIDTH'(0));
		offer(AMOUNT_WIDTH'(1));
		offer('1);
		offer(AMOUNT_WIDTH'(99));
		offer(AMOUNT_WIDTH'(41));
		offer(AMOUNT_WIDTH'(4));

		// unsorted registers with a zero one and the largest coin; junk write too
		drain();
		program_regs(16'd3, 16'hFFFF, 16'd7, 16'd0, 16'd4, 1'b1);
		offer('1);
		offer(AMOUNT_WIDTH'(65534));
		offer(AMOUNT_WIDTH'(1));
		offer(AMOUNT_WIDTH'(10));
		offer(AMOUNT_WIDTH'(0));

		// nothing in use: only zero can be made
		drain();
		program_regs(16'd3, 16'hFFFF, 16'd7, 16'd0, 16'hFFF8, 1'b0);
		offer(AMOUNT_WIDTH'(0));
		offer(AMOUNT_WIDTH'(5));

		// in-use field at 7 must saturate to the register count
		drain();
		program_regs(16'd2, 16'd8, 16'd4, 16'd6, 16'hFFFF, 1'b0);
		offer(AMOUNT_WIDTH'(7));
		offer(AMOUNT_WIDTH'(20));
		offer('1);

		// single unit coin: largest possible count
		drain();
		program_regs(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 1'b0);
		offer('1);
		offer(AMOUNT_WIDTH'(12345));

		// every coin at the top value
		drain();
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4, 1'b0);
		offer('1);
		offer(AMOUNT_WIDTH'(65534));

		// random settings; idling varies per phase and stops for the last one
		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			program_regs(rand_denom(), rand_denom(), rand_denom(), rand_denom(),
				rand_in_use_word(), $urandom_range(0, 3) == 0);
			idle_pct = (p == NUM_PHASES - 1) ? 0 : 20 * int'($urandom_range(0, 2));
			if (p == HOLD_PHASE)
				hold_req <= 1'b1;
			for (k = 0; k < ITEMS_PER_PHASE; k++)
				offer(pick_amount());
		end

		drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Run covered %0d amounts over %0d coin settings,", sent, settings);
		$display("with zero and over-range coin counts, zero coins, stray writes and a long stall.");
		if (mismatches == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/gcc_pkg.sv
rtl/core/gcc_cell.sv
rtl/core/gcc_divider.sv
rtl/core/greedy_coin_change.sv
verif/coin_change_checker.sv
verif/greedy_coin_change_test.sv
